@@ rtl/core/phc_pkg.sv @@
`default_nettype none

package phc_pkg;

  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned CsumOffset  = 12;
  localparam int unsigned RidOffset   = 4;
  localparam int unsigned AuthOffset  = 16;

  localparam int unsigned HdrIdxW = $clog2(HeaderBytes);

  // packet class codes
  localparam logic [1:0] ClassHello  = 2'd0;
  localparam logic [1:0] ClassUpdate = 2'd1;
  localparam logic [1:0] ClassOther  = 2'd2;

  typedef enum logic [2:0] {
    CfgLocalArea    = 3'd0,
    CfgExpVersion   = 3'd1,
    CfgExpAuthKind  = 3'd2,
    CfgExpAuthData  = 3'd3,
    CfgHelloCode    = 3'd4,
    CfgUpdateCode   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic        version_bad;
    logic        auth_bad;
    logic        checksum_bad;
    logic        area_bad;
    logic        too_short;
    logic [1:0]  packet_class;
    logic [31:0] sender_router;
    logic [15:0] declared_length;
  } out_word_t;

  typedef logic [HeaderBytes-1:0][7:0] hdr_bytes_t;

  // ones'-complement add with end-around carry
  function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pwospf_header_checker.sv @@
// pwospf_header_checker: header check for routing packets streamed a byte at a time
//
// input channel: in_valid_i / in_stall_o carry one word (data byte plus last flag)
// per cycle. the 24-byte header is captured and a ones'-complement checksum runs
// over the whole packet, with the checksum field itself counted as zero.
// output channel: out_valid_o / out_stall_i carry one verdict word, only for the
// last byte of a packet; other bytes produce nothing.
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i selecting the register;
// ready is always high, writes should happen only while the block is idle.
// throughput: one byte per cycle unless stalled; one checksum add per byte pair.
// verdict path: an accepted last byte waits in the input register until it fires,
// then the result register loads its verdict.
// stall: while a verdict is held by out_stall_i, bytes that are not last keep
// flowing; a further last byte waits in the input register and in_stall_o rises.
// reset: asynchronous, active low; clears packet state, empties both registers and
// loads the register defaults (version 2, hello type 1, update type 4, rest zero).
`default_nettype none

module pwospf_header_checker
  import phc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire in_word_t    in_word_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      out_word_t   out_word_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  // config registers
  logic [31:0] local_area_q;
  logic [7:0]  exp_version_q;
  logic [15:0] exp_auth_kind_q;
  logic [63:0] exp_auth_data_q;
  logic [7:0]  hello_code_q;
  logic [7:0]  update_code_q;

  logic        in_valid_q;
  in_word_t    in_q;
  logic        out_valid_q;
  out_word_t   out_q;

  logic [15:0] pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  hdr_bytes_t  hdr_q, hdr_d;

  logic        fire;
  logic        fire_last;
  logic        in_accept;
  logic        out_take;
  logic [7:0]  csum_byte;
  logic [15:0] addend;
  logic [15:0] sum_new;
  logic [15:0] pos_next;
  out_word_t   result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_area_q    <= '0;
      exp_version_q   <= 8'd2;
      exp_auth_kind_q <= '0;
      exp_auth_data_q <= '0;
      hello_code_q    <= 8'd1;
      update_code_q   <= 8'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgLocalArea:   local_area_q    <= cfg_data_i[31:0];
        CfgExpVersion:  exp_version_q   <= cfg_data_i[7:0];
        CfgExpAuthKind: exp_auth_kind_q <= cfg_data_i[15:0];
        CfgExpAuthData: exp_auth_data_q <= cfg_data_i;
        CfgHelloCode:   hello_code_q    <= cfg_data_i[7:0];
        CfgUpdateCode:  update_code_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_take   = out_valid_q && !out_stall_i;
  assign fire       = in_valid_q && (!in_q.last_byte || !out_valid_q || !out_stall_i);
  assign fire_last  = fire && in_q.last_byte;
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_word_i;
    end
  end

  // per-byte datapath
  assign csum_byte = (pos_q == 16'(CsumOffset) || pos_q == 16'(CsumOffset + 1))
                     ? 8'h00 : in_q.data_byte;
  // even position closes an odd-length packet with a zero pad byte
  assign addend    = pos_q[0] ? {pend_q, csum_byte} : {csum_byte, 8'h00};
  assign sum_new   = add_ones(sum_q, addend);
  assign pos_next  = pos_q + 16'd1;

  always_comb begin
    hdr_d = hdr_q;
    if (pos_q < 16'(HeaderBytes)) begin
      hdr_d[pos_q[HdrIdxW-1:0]] = in_q.data_byte;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    pend_d = pend_q;
    if (fire) begin
      if (in_q.last_byte) begin
        pos_d  = '0;
        sum_d  = '0;
        pend_d = '0;
      end else begin
        pos_d = (pos_next == 16'd0) ? 16'hFFFE : pos_next;
        if (pos_q[0]) begin
          sum_d  = sum_new;
          pend_d = '0;
        end else begin
          pend_d = csum_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      pend_q <= '0;
      hdr_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      pend_q <= pend_d;
      if (fire_last) begin
        hdr_q <= '0;
      end else if (fire) begin
        hdr_q <= hdr_d;
      end
    end
  end

  // verdict, evaluated on the header including the final byte
  always_comb begin
    result                 = '0;
    result.version_bad     = hdr_d[0] != exp_version_q;
    result.auth_bad        = ({hdr_d[14], hdr_d[15]} != exp_auth_kind_q) ||
                             ({hdr_d[AuthOffset],   hdr_d[AuthOffset+1],
                               hdr_d[AuthOffset+2], hdr_d[AuthOffset+3],
                               hdr_d[AuthOffset+4], hdr_d[AuthOffset+5],
                               hdr_d[AuthOffset+6], hdr_d[AuthOffset+7]}
                              != exp_auth_data_q);
    result.checksum_bad    = {hdr_d[CsumOffset], hdr_d[CsumOffset+1]} != ~sum_new;
    result.area_bad        = {hdr_d[8], hdr_d[9], hdr_d[10], hdr_d[11]} != local_area_q;
    result.too_short       = pos_q < 16'(HeaderBytes - 1);
    result.accepted        = !(result.version_bad || result.auth_bad ||
                               result.checksum_bad || result.area_bad ||
                               result.too_short);
    if (hdr_d[1] == hello_code_q) begin
      result.packet_class = ClassHello;
    end else if (hdr_d[1] == update_code_q) begin
      result.packet_class = ClassUpdate;
    end else begin
      result.packet_class = ClassOther;
    end
    result.sender_router   = {hdr_d[RidOffset], hdr_d[RidOffset+1],
                              hdr_d[RidOffset+2], hdr_d[RidOffset+3]};
    result.declared_length = {hdr_d[2], hdr_d[3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_last) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // a verdict only ever follows a processed last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fire_last))
    else $error("verdict without a last byte");

  // packet state is clean after a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_last |=> (pos_q == 16'd0 && sum_q == 16'd0 && pend_q == 8'd0))
    else $error("packet state not cleared");

  // a middle byte never leaves the position at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_q.last_byte) |=> pos_q != 16'd0)
    else $error("position did not advance");

  // a held verdict is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !fire_last)
    else $error("verdict overwritten while stalled");

endmodule

`default_nettype wire
